// ----- hdl/ata_seq_pkg.sv -----
`default_nettype none
package ata_seq_pkg;

  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_RD   = 3'd1,
    OP_RDM  = 3'd2,
    OP_WR   = 3'd3,
    OP_WRM  = 3'd4
  } op_e;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_IMG_SEND = 3'd1;
  localparam logic [2:0] ACT_IMG_RECV = 3'd2;
  localparam logic [2:0] ACT_VIRT     = 3'd3;
  localparam logic [2:0] ACT_IDENT    = 3'd4;
  localparam logic [2:0] ACT_DISCARD  = 3'd5;

  localparam logic [7:0] ST_NONE = 8'h00;
  localparam logic [7:0] ST_END  = 8'h80;
  localparam logic [7:0] ST_IRQ  = 8'h10;
  localparam logic [7:0] ST_RDY  = 8'h08;
  localparam logic [7:0] ST_REQ  = 8'h04;
  localparam logic [7:0] ST_DONE = 8'h90;
  localparam logic [7:0] ST_FAIL = 8'h91;

  localparam logic [7:0] CMD_GRP_MASK = 8'hF0;
  localparam logic [7:0] CMD_RECAL    = 8'h10;
  localparam logic [7:0] CMD_DIAG     = 8'h90;
  localparam logic [7:0] CMD_IDENT    = 8'hEC;
  localparam logic [7:0] CMD_INIT     = 8'h91;
  localparam logic [7:0] CMD_RD       = 8'h20;
  localparam logic [7:0] CMD_RDM      = 8'hC4;
  localparam logic [7:0] CMD_WR       = 8'h30;
  localparam logic [7:0] CMD_WRM      = 8'hC5;
  localparam logic [7:0] CMD_SETMULT  = 8'hC6;

  localparam logic [7:0] ERR_DIAG_OK = 8'h01;
  localparam logic [7:0] ERR_ABORT   = 8'h04;

  typedef struct packed {
    logic [7:0]  sector;
    logic [3:0]  head;
    logic [15:0] cyl;
  } chs_t;

  typedef struct packed {
    logic [7:0] spt;
    logic [4:0] heads;
  } geo_t;

  typedef struct packed {
    logic [7:0]  status;
    logic        tf;
    logic [7:0]  err;
    logic [7:0]  cnt;
    logic [7:0]  sec;
    logic [15:0] cyl;
    logic [7:0]  dh;
    logic [2:0]  act;
    logic [27:0] blk;
    logic        done;
  } res_t;

  function automatic logic [15:0] g_cyls(input logic [41:0] g);
    return g[15:0];
  endfunction
  function automatic logic [4:0] g_heads(input logic [41:0] g);
    return g[20:16];
  endfunction
  function automatic logic [7:0] g_spt(input logic [41:0] g);
    return g[28:21];
  endfunction
  function automatic logic [11:0] g_vbb(input logic [41:0] g);
    return g[40:29];
  endfunction
  function automatic logic g_en(input logic [41:0] g);
    return g[41];
  endfunction

  // task file fields read as zero when not written back
  function automatic res_t mk_res(input logic [7:0] st, input logic tf, input logic [7:0] err,
                                  input logic [7:0] cnt, input logic [7:0] sec,
                                  input logic [15:0] cyl, input logic [7:0] dh,
                                  input logic [2:0] act, input logic [27:0] blk,
                                  input logic done);
    res_t r;
    r.status = st;
    r.tf     = tf;
    r.err    = tf ? err : 8'h00;
    r.cnt    = tf ? cnt : 8'h00;
    r.sec    = tf ? sec : 8'h00;
    r.cyl    = tf ? cyl : 16'h0000;
    r.dh     = tf ? dh : 8'h00;
    r.act    = act;
    r.blk    = blk;
    r.done   = done;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ata_seq_chs.sv -----
`default_nettype none
module ata_seq_chs
  import ata_seq_pkg::*;
(
  input  chs_t cur_i,
  input  geo_t geo_i,
  output chs_t nxt_o
);

  logic [3:0] head_inc;

  assign head_inc = cur_i.head + 4'd1;

  always_comb begin
    nxt_o = cur_i;
    if (cur_i.sector == geo_i.spt) begin
      nxt_o.sector = 8'd1;
      if ({1'b0, head_inc} == geo_i.heads) begin
        nxt_o.head = 4'd0;
        nxt_o.cyl  = cur_i.cyl + 16'd1;
      end else begin
        nxt_o.head = head_inc;
      end
    end else begin
      nxt_o.sector = cur_i.sector + 8'd1;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ata_pio_command_sequencer.sv -----
// emulated ide drive command sequencer
// input channel: in_valid_i / in_stall_o carry one item, either a command
// (mode 0, the task file) or a host buffer ready event (mode 1).
// output channel: out_valid_o / out_stall_i carry at most one result item
// per input item: status, task file write back, transfer action and image
// block number. cfg_we_i writes one unit geometry register per cycle.
// plain commands and single sector buffer events give their result in the
// cycle after acceptance. read, write and multiple commands run the chs to
// block conversion on one shared 22x8 multiplier, through S_MUL1, S_MUL2
// and S_START. a read multiple buffer event steps chs one sector a cycle
// through the group before its result is registered.
// one item at a time: in_stall_o is high while an item is in work and while
// a result waits; a stalled result holds on the output register.
// reset: no transfer active, geometry all zero, multiple count one per unit.
`default_nettype none
module ata_pio_command_sequencer
  import ata_seq_pkg::*;
#(
  parameter int UNITS        = 4,
  parameter int MAX_TRANSFER = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [41:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        mode_i,
  input  wire logic [7:0]  command_i,
  input  wire logic [7:0]  sector_count_i,
  input  wire logic [7:0]  sector_number_i,
  input  wire logic [15:0] cylinder_i,
  input  wire logic [7:0]  drive_head_i,
  input  wire logic [1:0]  unit_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       status_o,
  output logic             taskfile_valid_o,
  output logic [7:0]       error_reg_o,
  output logic [7:0]       count_out_o,
  output logic [7:0]       sector_out_o,
  output logic [15:0]      cylinder_out_o,
  output logic [7:0]       drive_head_out_o,
  output logic [2:0]       action_o,
  output logic [27:0]      image_block_o,
  output logic             done_res_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL1  = 5'b00010,
    S_MUL2  = 5'b00100,
    S_START = 5'b01000,
    S_GROUP = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  op_e         op_q, op_d, pend_q, pend_d;
  logic [1:0]  unit_q, unit_d;
  logic [3:0]  dbits_q, dbits_d;
  logic [7:0]  ocnt_q, ocnt_d;
  chs_t        pos_q, pos_d, pos_step;
  logic [8:0]  rem_q, rem_d;
  logic [28:0] lba_q, lba_d;
  logic [7:0]  bl_q, bl_d;
  logic [7:0]  grp_q, grp_d;
  logic [7:0]  gcnt_q, gcnt_d;
  logic [27:0] blk_q, blk_d;
  logic [29:0] prod_q, prod_d;
  res_t        out_q, out_d;
  logic        ovld_q, ovld_d;
  logic [41:0] geo_q [4];
  logic [7:0]  mc_q [UNITS];
  logic [7:0]  mc_d [UNITS];

  logic [41:0] geo_act;
  logic [11:0] v_act;
  logic        lba_ge;
  logic [27:0] blk_cur;
  logic [7:0]  mult_act;
  logic [21:0] mul_a;
  logic [7:0]  mul_b;
  logic [29:0] mul_p;
  logic        in_acc;
  geo_t        step_geo;

  assign geo_act  = geo_q[unit_q];
  assign v_act    = g_vbb(geo_act);
  assign lba_ge   = lba_q >= {17'd0, v_act};
  assign blk_cur  = lba_ge ? 28'(lba_q - {17'd0, v_act}) : 28'd0;
  assign step_geo = '{spt: g_spt(geo_act), heads: g_heads(geo_act)};

  ata_seq_chs u_chs (
    .cur_i (pos_q),
    .geo_i (step_geo),
    .nxt_o (pos_step)
  );

  // multiple count of the active unit, zero treated as one
  always_comb begin
    mult_act = 8'd1;
    for (int i = 0; i < UNITS; i++) begin
      if (unit_q == 2'(i) && mc_q[i] != 8'd0) mult_act = mc_q[i];
    end
  end

  // shared multiplier: cylinder * heads, then (that + head) * sectors
  always_comb begin
    if (state_q == S_MUL2) begin
      mul_a = prod_q[21:0] + {18'd0, pos_q.head};
      mul_b = g_spt(geo_act);
    end else begin
      mul_a = {6'd0, pos_q.cyl};
      mul_b = {3'd0, g_heads(geo_act)};
    end
  end
  assign mul_p = {8'd0, mul_a} * {22'd0, mul_b};

  assign in_stall_o = (state_q != S_IDLE) || ovld_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    logic        last;
    logic        imm;
    logic        below;
    logic        tf;
    logic [7:0]  st;
    logic [2:0]  act;
    logic [27:0] blk;
    logic [8:0]  rem_n;
    logic [7:0]  bl_n;
    logic [8:0]  n9;
    logic [28:0] lba_s;
    logic        reject;
    chs_t        pn;

    state_d = state_q;
    op_d    = op_q;
    pend_d  = pend_q;
    unit_d  = unit_q;
    dbits_d = dbits_q;
    ocnt_d  = ocnt_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    lba_d   = lba_q;
    bl_d    = bl_q;
    grp_d   = grp_q;
    gcnt_d  = gcnt_q;
    blk_d   = blk_q;
    prod_d  = prod_q;
    out_d   = out_q;
    ovld_d  = ovld_q && out_stall_i;
    mc_d    = mc_q;

    last   = 1'b0;
    imm    = 1'b0;
    below  = !lba_ge;
    tf     = 1'b1;
    st     = ST_IRQ;
    act    = ACT_NONE;
    blk    = 28'd0;
    rem_n  = 9'd0;
    bl_n   = 8'd0;
    n9     = (ocnt_q == 8'd0) ? 9'd256 : {1'b0, ocnt_q};
    if (n9 > 9'(MAX_TRANSFER)) n9 = 9'(MAX_TRANSFER);
    lba_s  = 29'(prod_q + {22'd0, pos_q.sector} - 30'd1);
    reject = !g_en(geo_act) || (32'(unit_q) >= UNITS) ||
             (prod_q == 30'd0 && pos_q.sector == 8'd0);
    pn     = (rem_q != 9'd1) ? pos_step : pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc && !mode_i) begin
          op_d = OP_IDLE;
          if ((command_i & CMD_GRP_MASK) == CMD_RECAL) begin
            out_d  = mk_res(ST_DONE, 1'b1, 8'd0, 8'd0, 8'd1, 16'd0,
                            drive_head_i & CMD_GRP_MASK, ACT_NONE, 28'd0, 1'b1);
            ovld_d = 1'b1;
          end else if (command_i == CMD_DIAG) begin
            out_d  = mk_res(ST_DONE, 1'b1, ERR_DIAG_OK, 8'd0, 8'd0, 16'd0, 8'd0,
                            ACT_NONE, 28'd0, 1'b1);
            ovld_d = 1'b1;
          end else if (command_i == CMD_IDENT || command_i == CMD_INIT) begin
            out_d  = mk_res(ST_DONE, 1'b1, 8'd0, sector_count_i, sector_number_i,
                            cylinder_i, drive_head_i,
                            (command_i == CMD_IDENT) ? ACT_IDENT : ACT_NONE, 28'd0, 1'b1);
            ovld_d = 1'b1;
          end else if (command_i == CMD_SETMULT) begin
            for (int i = 0; i < UNITS; i++) begin
              if (unit_i == 2'(i)) mc_d[i] = sector_count_i;
            end
            out_d  = mk_res(ST_DONE, 1'b0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0,
                            ACT_NONE, 28'd0, 1'b1);
            ovld_d = 1'b1;
          end else if (command_i == CMD_RD || command_i == CMD_RDM ||
                       command_i == CMD_WR || command_i == CMD_WRM) begin
            case (command_i)
              CMD_RD:  pend_d = OP_RD;
              CMD_RDM: pend_d = OP_RDM;
              CMD_WR:  pend_d = OP_WR;
              default: pend_d = OP_WRM;
            endcase
            unit_d  = unit_i;
            dbits_d = drive_head_i[7:4];
            ocnt_d  = sector_count_i;
            pos_d   = '{sector: sector_number_i, head: drive_head_i[3:0], cyl: cylinder_i};
            state_d = S_MUL1;
          end else begin
            out_d  = mk_res(ST_FAIL, 1'b1, ERR_ABORT, sector_count_i, sector_number_i,
                            cylinder_i, drive_head_i, ACT_NONE, 28'd0, 1'b1);
            ovld_d = 1'b1;
          end
        end else if (in_acc) begin
          case (op_q)
            OP_RD: begin
              last  = rem_q <= 9'd1;
              act   = below ? ACT_VIRT : ACT_IMG_SEND;
              blk   = below ? 28'd0 : blk_cur;
              imm   = below || (unit_q == 2'd0 && lba_q == 29'd0);
              st    = (imm && last) ? ST_DONE : ST_IRQ;
              pos_d = pn;
              lba_d = lba_q + 29'd1;
              rem_d = last ? 9'd0 : rem_q - 9'd1;
              if (last) op_d = OP_IDLE;
              out_d  = mk_res(st, 1'b1, 8'd0, ocnt_q, pn.sector, pn.cyl,
                              {dbits_q, pn.head}, act, blk, last);
              ovld_d = 1'b1;
            end
            OP_WR, OP_WRM: begin
              act   = below ? ACT_DISCARD : ACT_IMG_RECV;
              blk   = below ? 28'd0 : blk_cur;
              rem_n = (rem_q <= 9'd1) ? 9'd0 : rem_q - 9'd1;
              last  = rem_n == 9'd0;
              st    = last ? ST_DONE : ST_IRQ;
              pos_d = pn;
              lba_d = lba_q + 29'd1;
              rem_d = rem_n;
              if (op_q == OP_WRM) begin
                bl_n = (bl_q <= 8'd1) ? 8'd0 : bl_q - 8'd1;
                if (bl_n == 8'd0 || last) begin
                  bl_d = (rem_n < {1'b0, mult_act}) ? rem_n[7:0] : mult_act;
                end else begin
                  bl_d = bl_n;
                  tf   = 1'b0;
                  st   = ST_NONE;
                end
              end
              if (last) op_d = OP_IDLE;
              out_d  = mk_res(st, tf, 8'd0, ocnt_q, pn.sector, pn.cyl,
                              {dbits_q, pn.head}, act, blk, last);
              ovld_d = 1'b1;
            end
            OP_RDM: begin
              grp_d   = (rem_q < {1'b0, mult_act}) ? rem_q[7:0] : mult_act;
              gcnt_d  = (rem_q < {1'b0, mult_act}) ? rem_q[7:0] : mult_act;
              blk_d   = blk_cur;
              state_d = S_GROUP;
            end
            default: ;
          endcase
        end
      end
      S_MUL1: begin
        prod_d  = mul_p;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = mul_p;
        state_d = S_START;
      end
      S_START: begin
        state_d = S_IDLE;
        if (reject) begin
          if (pend_q != OP_RD) begin
            out_d  = mk_res((pend_q == OP_RDM) ? ST_END : ST_REQ, 1'b0, 8'd0, 8'd0,
                            8'd0, 16'd0, 8'd0, ACT_NONE, 28'd0, 1'b1);
            ovld_d = 1'b1;
          end
        end else begin
          op_d  = pend_q;
          rem_d = n9;
          lba_d = (pend_q == OP_RDM && lba_s < {17'd0, v_act}) ? {17'd0, v_act} : lba_s;
          bl_d  = (n9 < {1'b0, mult_act}) ? n9[7:0] : mult_act;
          out_d = mk_res((pend_q == OP_RD || pend_q == OP_RDM) ? ST_RDY : ST_REQ, 1'b0,
                         8'd0, 8'd0, 8'd0, 16'd0, 8'd0, ACT_NONE, 28'd0, 1'b0);
          ovld_d = 1'b1;
        end
      end
      S_GROUP: begin
        if (gcnt_q == 8'd0) begin
          last    = rem_q == 9'd0;
          lba_d   = lba_q + {21'd0, grp_q};
          if (last) op_d = OP_IDLE;
          out_d   = mk_res(last ? ST_DONE : ST_IRQ, 1'b1, 8'd0, ocnt_q, pos_q.sector,
                           pos_q.cyl, {dbits_q, pos_q.head}, ACT_IMG_SEND, blk_q, last);
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d  = pn;
          rem_d  = rem_q - 9'd1;
          gcnt_d = gcnt_q - 8'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_IDLE;
      pend_q  <= OP_IDLE;
      unit_q  <= 2'd0;
      dbits_q <= 4'd0;
      ocnt_q  <= 8'd0;
      pos_q   <= '0;
      rem_q   <= 9'd0;
      lba_q   <= 29'd0;
      bl_q    <= 8'd0;
      grp_q   <= 8'd0;
      gcnt_q  <= 8'd0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < 4; i++) geo_q[i] <= 42'd0;
      for (int i = 0; i < UNITS; i++) mc_q[i] <= 8'd1;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      pend_q  <= pend_d;
      unit_q  <= unit_d;
      dbits_q <= dbits_d;
      ocnt_q  <= ocnt_d;
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      lba_q   <= lba_d;
      bl_q    <= bl_d;
      grp_q   <= grp_d;
      gcnt_q  <= gcnt_d;
      ovld_q  <= ovld_d;
      mc_q    <= mc_d;
      if (cfg_we_i) geo_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o      = ovld_q;
  assign status_o         = out_q.status;
  assign taskfile_valid_o = out_q.tf;
  assign error_reg_o      = out_q.err;
  assign count_out_o      = out_q.cnt;
  assign sector_out_o     = out_q.sec;
  assign cylinder_out_o   = out_q.cyl;
  assign drive_head_out_o = out_q.dh;
  assign action_o         = out_q.act;
  assign image_block_o    = out_q.blk;
  assign done_res_o       = out_q.done;

endmodule
`default_nettype wire

// ----- hdl/ata_seq_sva.sv -----
`default_nettype none
module ata_seq_sva
  import ata_seq_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        taskfile_valid_o,
  input wire logic [7:0]  error_reg_o,
  input wire logic [7:0]  count_out_o,
  input wire logic [2:0]  action_o,
  input wire logic [27:0] image_block_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(image_block_o))
    else $error("stalled result dropped or changed");

  // no new item while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("item taken while result pending");

  // task file fields are zero when not written back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !taskfile_valid_o |-> error_reg_o == 8'd0 && count_out_o == 8'd0)
    else $error("task file fields set without write back");

  // image block only on image transfers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != ACT_IMG_SEND && action_o != ACT_IMG_RECV
      |-> image_block_o == 28'd0)
    else $error("image block outside image transfer");

endmodule

bind ata_pio_command_sequencer ata_seq_sva u_sva (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .taskfile_valid_o (taskfile_valid_o),
  .error_reg_o      (error_reg_o),
  .count_out_o      (count_out_o),
  .action_o         (action_o),
  .image_block_o    (image_block_o)
);
`default_nettype wire

// ----- bench/tb_ata_pio_command_sequencer.sv -----
`default_nettype none
module tb_ata_pio_command_sequencer;
  import ata_seq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int PHASE_ITEMS    = 180;

  typedef struct packed {
    logic        mode;
    logic [7:0]  cmd;
    logic [7:0]  cnt;
    logic [7:0]  sec;
    logic [15:0] cyl;
    logic [7:0]  dh;
    logic [1:0]  unit;
  } task_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [41:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [7:0]  command_i = '0;
  logic [7:0]  sector_count_i = '0;
  logic [7:0]  sector_number_i = '0;
  logic [15:0] cylinder_i = '0;
  logic [7:0]  drive_head_i = '0;
  logic [1:0]  unit_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [7:0]  status_o;
  logic        taskfile_valid_o;
  logic [7:0]  error_reg_o;
  logic [7:0]  count_out_o;
  logic [7:0]  sector_out_o;
  logic [15:0] cylinder_out_o;
  logic [7:0]  drive_head_out_o;
  logic [2:0]  action_o;
  logic [27:0] image_block_o;
  logic        done_res_o;

  ata_pio_command_sequencer uut (.*);

  always #10 clk_i = ~clk_i;

  // drive model state
  logic [41:0] geo_reg [4];
  op_e         xfer_op;
  logic [1:0]  xfer_unit;
  logic [3:0]  xfer_dbits;
  logic [7:0]  xfer_count;
  logic [7:0]  chs_sec;
  logic [3:0]  chs_head;
  logic [15:0] chs_cyl;
  int          sectors_left;
  logic [28:0] block_pos;
  int          group_left;
  logic [7:0]  mult_cnt [4];

  task_item_t  pending_items[$];
  res_t        expected_results[$];
  task_item_t  drv_item;
  logic        in_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 0;
  bit          steady = 0;
  int          idle_cycles = 0;
  int          mismatches = 0;
  int          items_in = 0;
  int          cmd_items = 0;
  int          results_seen = 0;
  int          generated = 0;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] mult_of(input logic [1:0] u);
    return (mult_cnt[u] == 8'd0) ? 8'd1 : mult_cnt[u];
  endfunction

  function automatic res_t make_res(input logic [7:0] st, input logic tf,
                                    input logic [7:0] err, input logic [7:0] cnt,
                                    input logic [7:0] sec, input logic [15:0] cyl,
                                    input logic [7:0] dh, input logic [2:0] act,
                                    input logic [27:0] blk, input logic done);
    res_t r;
    r = '0;
    r.status = st;
    r.tf = tf;
    if (tf) begin
      r.err = err;
      r.cnt = cnt;
      r.sec = sec;
      r.cyl = cyl;
      r.dh  = dh;
    end
    r.act  = act;
    r.blk  = blk;
    r.done = done;
    return r;
  endfunction

  function automatic res_t xfer_res(input logic [7:0] st, input logic tf, input logic [2:0] act,
                                    input logic [27:0] blk, input logic done);
    return make_res(st, tf, 8'h00, xfer_count, chs_sec, chs_cyl, {xfer_dbits, chs_head},
                    act, blk, done);
  endfunction

  function automatic void advance_chs();
    if (chs_sec == geo_reg[xfer_unit][28:21]) begin
      chs_sec = 8'd1;
      chs_head = chs_head + 4'd1;
      if ({1'b0, chs_head} == geo_reg[xfer_unit][20:16]) begin
        chs_head = 4'd0;
        chs_cyl = chs_cyl + 16'd1;
      end
    end else begin
      chs_sec = chs_sec + 8'd1;
    end
  endfunction

  function automatic bit open_transfer(input task_item_t it, input op_e op, output res_t r);
    logic [31:0] base;
    logic [28:0] lba;
    logic [11:0] v;
    int n;
    r = '0;
    xfer_op = OP_IDLE;
    base = (32'(it.cyl) * 32'(geo_reg[it.unit][20:16]) + 32'(it.dh[3:0]))
           * 32'(geo_reg[it.unit][28:21]);
    if (!geo_reg[it.unit][41] || (base == 0 && it.sec == 0)) begin
      if (op == OP_RD) return 0;
      r = make_res((op == OP_RDM) ? ST_END : ST_REQ, 1'b0, '0, '0, '0, '0, '0, ACT_NONE,
                   '0, 1'b1);
      return 1;
    end
    lba = 29'(base + 32'(it.sec) - 32'd1);
    v = geo_reg[it.unit][40:29];
    n = (it.cnt == 0) ? 256 : int'(it.cnt);
    xfer_op = op;
    xfer_unit = it.unit;
    xfer_dbits = it.dh[7:4];
    xfer_count = it.cnt;
    chs_sec = it.sec;
    chs_head = it.dh[3:0];
    chs_cyl = it.cyl;
    sectors_left = n;
    block_pos = (op == OP_RDM && lba < 29'(v)) ? 29'(v) : lba;
    group_left = (n < int'(mult_of(it.unit))) ? n : int'(mult_of(it.unit));
    r = make_res((op == OP_RD || op == OP_RDM) ? ST_RDY : ST_REQ, 1'b0, '0, '0, '0, '0, '0,
                 ACT_NONE, '0, 1'b0);
    return 1;
  endfunction

  function automatic bit buffer_ready(output res_t r);
    logic [11:0] v;
    logic [28:0] lba;
    logic [27:0] blk;
    logic [2:0]  act;
    logic [7:0]  st;
    bit last, imm, tf;
    int grp, m;
    r = '0;
    v = geo_reg[xfer_unit][40:29];
    lba = block_pos;
    blk = (lba >= 29'(v)) ? 28'(lba - 29'(v)) : '0;
    case (xfer_op)
      OP_RD: begin
        if (sectors_left != 1) advance_chs();
        last = sectors_left <= 1;
        if (lba < 29'(v)) begin
          act = ACT_VIRT;
          blk = '0;
          imm = 1;
        end else begin
          act = ACT_IMG_SEND;
          imm = (xfer_unit == 2'd0 && lba == 0);
        end
        st = (imm && last) ? ST_DONE : ST_IRQ;
        block_pos = block_pos + 29'd1;
        sectors_left = last ? 0 : sectors_left - 1;
        if (last) xfer_op = OP_IDLE;
        r = xfer_res(st, 1'b1, act, blk, last);
        return 1;
      end
      OP_RDM: begin
        m = int'(mult_of(xfer_unit));
        grp = (sectors_left < m) ? sectors_left : m;
        for (int k = 0; k < grp; k++) begin
          if (sectors_left != 1) advance_chs();
          sectors_left--;
        end
        block_pos = block_pos + 29'(grp);
        last = sectors_left == 0;
        if (last) xfer_op = OP_IDLE;
        r = xfer_res(last ? ST_DONE : ST_IRQ, 1'b1, ACT_IMG_SEND, blk, last);
        return 1;
      end
      OP_WR, OP_WRM: begin
        tf = 1;
        if (sectors_left != 1) advance_chs();
        act = (lba >= 29'(v)) ? ACT_IMG_RECV : ACT_DISCARD;
        if (act == ACT_DISCARD) blk = '0;
        block_pos = block_pos + 29'd1;
        sectors_left = (sectors_left <= 1) ? 0 : sectors_left - 1;
        last = sectors_left == 0;
        st = last ? ST_DONE : ST_IRQ;
        if (xfer_op == OP_WRM) begin
          group_left = (group_left <= 1) ? 0 : group_left - 1;
          if (group_left == 0 || last) begin
            m = int'(mult_of(xfer_unit));
            group_left = (sectors_left < m) ? sectors_left : m;
          end else begin
            tf = 0;
            st = ST_NONE;
          end
        end
        if (last) xfer_op = OP_IDLE;
        r = xfer_res(st, tf, act, blk, last);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic bit predict_drive(input task_item_t it, output res_t r);
    r = '0;
    if (it.mode) return buffer_ready(r);
    xfer_op = OP_IDLE;
    if ((it.cmd & CMD_GRP_MASK) == CMD_RECAL)
      r = make_res(ST_DONE, 1'b1, '0, '0, 8'd1, '0, it.dh & 8'hF0, ACT_NONE, '0, 1'b1);
    else if (it.cmd == CMD_DIAG)
      r = make_res(ST_DONE, 1'b1, ERR_DIAG_OK, '0, '0, '0, '0, ACT_NONE, '0, 1'b1);
    else if (it.cmd == CMD_IDENT)
      r = make_res(ST_DONE, 1'b1, '0, it.cnt, it.sec, it.cyl, it.dh, ACT_IDENT, '0, 1'b1);
    else if (it.cmd == CMD_INIT)
      r = make_res(ST_DONE, 1'b1, '0, it.cnt, it.sec, it.cyl, it.dh, ACT_NONE, '0, 1'b1);
    else if (it.cmd == CMD_SETMULT) begin
      mult_cnt[it.unit] = it.cnt;
      r = make_res(ST_DONE, 1'b0, '0, '0, '0, '0, '0, ACT_NONE, '0, 1'b1);
    end else if (it.cmd == CMD_RD) return open_transfer(it, OP_RD, r);
    else if (it.cmd == CMD_RDM) return open_transfer(it, OP_RDM, r);
    else if (it.cmd == CMD_WR) return open_transfer(it, OP_WR, r);
    else if (it.cmd == CMD_WRM) return open_transfer(it, OP_WRM, r);
    else
      r = make_res(ST_FAIL, 1'b1, ERR_ABORT, it.cnt, it.sec, it.cyl, it.dh, ACT_NONE, '0,
                   1'b1);
    return 1;
  endfunction

  // monitor: result check, input acceptance and prediction, watchdog
  always @(posedge clk_i) begin
    res_t got, want, pred;
    bit fired;
    fired = 0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      fired = 1;
      results_seen++;
      got = '{status_o, taskfile_valid_o, error_reg_o, count_out_o, sector_out_o,
              cylinder_out_o, drive_head_out_o, action_o, image_block_o, done_res_o};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fired = 1;
      items_in++;
      if (!drv_item.mode) cmd_items++;
      if (predict_drive(drv_item, pred)) expected_results.push_back(pred);
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
    idle_cycles = fired ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("FAIL ata_pio_command_sequencer");
      $finish;
    end
  end

  // sender
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drv_item = pending_items.pop_front();
        mode_i <= drv_item.mode;
        command_i <= drv_item.cmd;
        sector_count_i <= drv_item.cnt;
        sector_number_i <= drv_item.sec;
        cylinder_i <= drv_item.cyl;
        drive_head_i <= drv_item.dh;
        unit_i <= drv_item.unit;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 59) == 0) steady = !steady;
        gap_left = steady ? 0 : rand_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off so the block backs up its input
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && items_in >= 400) begin
      hold_done = 1;
      hold_left = 400;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = steady ? 0 : rand_gap();
    end
  end

  task automatic write_geometry(input logic [1:0] idx, input logic [41:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    geo_reg[idx] = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic add_item(input logic mode, input logic [7:0] cmd, input logic [7:0] cnt,
                          input logic [7:0] sec, input logic [15:0] cyl, input logic [7:0] dh,
                          input logic [1:0] unit);
    pending_items.push_back('{mode, cmd, cnt, sec, cyl, dh, unit});
    generated++;
  endtask

  task automatic add_buffers(input int n);
    for (int i = 0; i < n; i++)
      add_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
               2'($urandom));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [41:0] rand_geometry();
    logic [41:0] g;
    int r;
    g[15:0] = 16'($urandom);
    r = $urandom_range(0, 19);
    g[20:16] = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(17, 31)) :
               5'($urandom_range(1, 16));
    r = $urandom_range(0, 19);
    g[28:21] = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(1, 63));
    r = $urandom_range(0, 3);
    g[40:29] = (r == 0) ? 12'd0 : (r == 1) ? 12'($urandom) : 12'($urandom_range(1, 20));
    g[41] = ($urandom_range(0, 7) != 0);
    return g;
  endfunction

  task automatic add_random_items(input int target);
    int stop, r, n, sent;
    logic [7:0] cmd, sec;
    logic [15:0] cyl;
    logic [7:0] dh;
    logic [1:0] u;
    stop = generated + target;
    while (generated < stop) begin
      r = $urandom_range(0, 99);
      u = 2'($urandom);
      if (r < 10) begin
        add_item(1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                 8'($urandom), 2'($urandom));
      end else if (r < 17) begin
        add_item(1'b0, CMD_SETMULT, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                 8'($urandom_range(0, 8)), 8'($urandom), 16'($urandom), 8'($urandom), u);
      end else if (r < 25) begin
        case ($urandom_range(0, 3))
          0: cmd = CMD_RECAL | 8'($urandom_range(0, 15));
          1: cmd = CMD_DIAG;
          2: cmd = CMD_IDENT;
          default: cmd = CMD_INIT;
        endcase
        add_item(1'b0, cmd, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), u);
      end else begin
        case ($urandom_range(0, 3))
          0: cmd = CMD_RD;
          1: cmd = CMD_RDM;
          2: cmd = CMD_WR;
          default: cmd = CMD_WRM;
        endcase
        r = $urandom_range(0, 59);
        n = (r == 0) ? 256 : (r < 6) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if ($urandom_range(0, 7) == 0) begin
          // start of the disk, where the virtual area and block zero sit
          sec = 8'd1;
          cyl = 16'd0;
          dh = {4'($urandom), 4'd0};
        end else begin
          sec = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
          cyl = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
          dh = 8'($urandom);
        end
        add_item(1'b0, cmd, 8'(n), sec, cyl, dh, u);
        sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
        add_buffers(sent);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 4; i++) begin
      geo_reg[i] = '0;
      mult_cnt[i] = 8'd1;
    end
    xfer_op = OP_IDLE;
    xfer_unit = '0;
    xfer_dbits = '0;
    xfer_count = '0;
    chs_sec = '0;
    chs_head = '0;
    chs_cyl = '0;
    sectors_left = 0;
    block_pos = '0;
    group_left = 0;
    drv_item = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // unit 0 with three virtual blocks, unit 2 off, unit 3 flat with no geometry
    write_geometry(2'd0, {1'b1, 12'd3, 8'd8, 5'd4, 16'd100});
    write_geometry(2'd1, {1'b1, 12'd0, 8'd63, 5'd16, 16'd1000});
    write_geometry(2'd2, {1'b0, 12'd0, 8'd8, 5'd4, 16'd100});
    write_geometry(2'd3, {1'b1, 12'd0, 8'd0, 5'd0, 16'd0});
    add_item(1'b0, 8'h1F, 8'h12, 8'h34, 16'h5678, 8'hAF, 2'd0);
    add_item(1'b0, CMD_DIAG, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 2'd1);
    add_item(1'b0, CMD_IDENT, 8'hFF, 8'h00, 16'hFFFF, 8'hF0, 2'd3);
    add_item(1'b0, CMD_INIT, 8'h00, 8'hFF, 16'h0000, 8'h0F, 2'd2);
    add_item(1'b0, 8'h00, 8'h01, 8'h02, 16'h0003, 8'h04, 2'd0);
    add_item(1'b0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 2'd3);
    add_buffers(1);                                              // nothing in progress
    add_item(1'b0, CMD_SETMULT, 8'd0, 8'd0, 16'd0, 8'd0, 2'd0);  // zero count acts as one
    add_item(1'b0, CMD_RD, 8'd2, 8'd1, 16'd0, 8'hA0, 2'd0);      // inside the virtual area
    add_buffers(2);
    add_item(1'b0, CMD_RD, 8'd1, 8'd1, 16'd0, 8'h00, 2'd2);      // unit switched off
    add_item(1'b0, CMD_RDM, 8'd1, 8'd1, 16'd0, 8'h00, 2'd2);
    add_item(1'b0, CMD_WR, 8'd1, 8'd1, 16'd0, 8'h00, 2'd2);
    add_item(1'b0, CMD_WRM, 8'd1, 8'd1, 16'd0, 8'h00, 2'd2);
    add_item(1'b0, CMD_RD, 8'd1, 8'd0, 16'd0, 8'h00, 2'd3);      // negative block number
    add_item(1'b0, CMD_SETMULT, 8'd4, 8'd0, 16'd0, 8'd0, 2'd1);
    add_item(1'b0, CMD_RDM, 8'd6, 8'd62, 16'd999, 8'hBF, 2'd1);  // wraps head and cylinder
    add_buffers(2);
    add_item(1'b0, CMD_WRM, 8'd5, 8'd60, 16'd2, 8'hEF, 2'd1);
    add_buffers(5);
    add_item(1'b0, CMD_RD, 8'd3, 8'd5, 16'd1, 8'h01, 2'd1);
    add_buffers(1);
    add_item(1'b0, CMD_DIAG, 8'd0, 8'd0, 16'd0, 8'd0, 2'd1);     // abandons the read
    add_item(1'b0, CMD_WR, 8'd2, 8'd1, 16'd0, 8'h00, 2'd0);
    add_buffers(2);
    drain();

    for (int phase = 1; phase <= 7; phase++) begin
      for (int i = 0; i < 4; i++) begin
        if (phase == 3) write_geometry(2'(i), {42{1'b1}});
        else if (phase == 5) write_geometry(2'(i), '0);
        else if (phase == 6 && i == 0) write_geometry(2'(i), {1'b1, 12'd0, 8'd4, 5'd2, 16'd9});
        else write_geometry(2'(i), rand_geometry());
      end
      add_random_items(PHASE_ITEMS);
      drain();
    end

    mismatches += expected_results.size();
    $display("%0d items accepted (%0d commands), %0d results checked over 8 geometry sets",
             items_in, cmd_items, results_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) $display("PASS ata_pio_command_sequencer");
    else $display("FAIL ata_pio_command_sequencer");
    $finish;
  end

endmodule
`default_nettype wire
